// File: hw/rtl/meter_uart_command_framer_unit_assert.svh
// assertion macros for the meter uart command framer
`ifndef METER_UART_COMMAND_FRAMER_UNIT_ASSERT_SVH
`define METER_UART_COMMAND_FRAMER_UNIT_ASSERT_SVH

// condition holds at every edge out of reset
`define MUCF_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define MUCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/mucf_pkg.sv
`default_nettype none

package mucf_pkg;

    localparam logic [7:0]  SYNC_BYTE = 8'hFE;
    localparam logic [15:0] ERR_DATA  = 16'hFFFF;
    localparam int          RW_BIT    = 7;

    localparam logic OP_CMD   = 1'b0;
    localparam logic OP_REPLY = 1'b1;

    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_RESULT = 1'b1;

    localparam logic [2:0] BEAT_SYNC = 3'd0;
    localparam logic [2:0] BEAT_ADDR = 3'd1;
    localparam logic [2:0] BEAT_MSB  = 3'd2;
    localparam logic [2:0] BEAT_LSB  = 3'd3;

    localparam logic [2:0] READ_FRAME_LEN  = 3'd3;
    localparam logic [2:0] WRITE_FRAME_LEN = 3'd5;

    localparam logic [1:0] CNT_MSB = 2'd0;
    localparam logic [1:0] CNT_LSB = 2'd1;
    localparam logic [1:0] CNT_CHK = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        frame_last;
        logic [15:0] read_data;
        logic        status;
    } beat_t;

endpackage

`default_nettype wire

// File: hw/rtl/mucf_engine.sv
`default_nettype none

module mucf_engine
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic           op,
    input  wire logic           is_read,
    input  wire logic [6:0]     reg_address,
    input  wire logic [15:0]    write_value,
    input  wire logic [7:0]     rx_byte,
    output logic                beat_push,
    input  wire logic           beat_ready,
    output mucf_pkg::beat_t     beat
);
    import mucf_pkg::*;

    logic        itm_vld_reg;
    logic        itm_op_reg;
    logic        itm_rd_reg;
    logic [6:0]  itm_addr_reg;
    logic [15:0] itm_val_reg;
    logic [7:0]  itm_rx_reg;
    logic [2:0]  beat_idx_reg;
    logic [2:0]  beat_idx_next;

    logic        awaiting_reg,  awaiting_next;
    logic        pend_rd_reg,   pend_rd_next;
    logic [1:0]  reply_cnt_reg, reply_cnt_next;
    logic [7:0]  reply_msb_reg, reply_msb_next;
    logic [7:0]  reply_lsb_reg, reply_lsb_next;
    logic [7:0]  sent_chk_reg,  sent_chk_next;

    logic [7:0]  addr_byte;
    logic [7:0]  msb_byte;
    logic [7:0]  lsb_byte;
    logic [7:0]  chk_byte;
    logic [7:0]  rd_expect;
    logic        reply_done;
    logic [2:0]  n_beats;
    logic [2:0]  last_idx;
    logic        done;
    logic        accept;

    always_comb
    begin
        addr_byte  = {itm_rd_reg, itm_addr_reg};
        msb_byte   = itm_val_reg[15:8];
        lsb_byte   = itm_val_reg[7:0];
        chk_byte   = itm_rd_reg ? addr_byte : 8'(addr_byte + msb_byte + lsb_byte);
        rd_expect  = 8'(reply_msb_reg + reply_lsb_reg);
        reply_done = awaiting_reg && (!pend_rd_reg || reply_cnt_reg == CNT_CHK);

        if (itm_op_reg == OP_CMD)
        begin
            n_beats = itm_rd_reg ? READ_FRAME_LEN : WRITE_FRAME_LEN;
        end
        else
        begin
            n_beats = reply_done ? 3'd1 : 3'd0;
        end
        last_idx = 3'(n_beats - 3'd1);

        beat = '0;
        if (itm_op_reg == OP_CMD)
        begin
            beat.kind = KIND_TX;
            priority if (beat_idx_reg == last_idx)
            begin
                beat.tx_byte    = chk_byte;
                beat.frame_last = 1'b1;
            end
            else if (beat_idx_reg == BEAT_SYNC)
            begin
                beat.tx_byte = SYNC_BYTE;
            end
            else if (beat_idx_reg == BEAT_ADDR)
            begin
                beat.tx_byte = addr_byte;
            end
            else if (beat_idx_reg == BEAT_MSB)
            begin
                beat.tx_byte = msb_byte;
            end
            else
            begin
                beat.tx_byte = lsb_byte;
            end
        end
        else
        begin
            beat.kind = KIND_RESULT;
            if (pend_rd_reg)
            begin
                beat.status    = (itm_rx_reg != rd_expect);
                beat.read_data = beat.status ? ERR_DATA : {reply_msb_reg, reply_lsb_reg};
            end
            else
            begin
                beat.status    = (itm_rx_reg != sent_chk_reg);
                beat.read_data = ERR_DATA;
            end
        end

        beat_push = itm_vld_reg && (n_beats != 3'd0) && beat_ready;
        done      = itm_vld_reg && ((n_beats == 3'd0) || (beat_push && beat_idx_reg == last_idx));
        in_ready  = !itm_vld_reg || done;
        accept    = in_valid && in_ready;

        beat_idx_next = beat_idx_reg;
        if (accept)
        begin
            beat_idx_next = BEAT_SYNC;
        end
        else if (beat_push)
        begin
            beat_idx_next = 3'(beat_idx_reg + 3'd1);
        end

        awaiting_next  = awaiting_reg;
        pend_rd_next   = pend_rd_reg;
        reply_cnt_next = reply_cnt_reg;
        reply_msb_next = reply_msb_reg;
        reply_lsb_next = reply_lsb_reg;
        sent_chk_next  = sent_chk_reg;
        if (done)
        begin
            if (itm_op_reg == OP_CMD)
            begin
                awaiting_next  = 1'b1;
                pend_rd_next   = itm_rd_reg;
                reply_cnt_next = CNT_MSB;
                reply_msb_next = '0;
                reply_lsb_next = '0;
                sent_chk_next  = chk_byte;
            end
            else if (awaiting_reg)
            begin
                priority if (pend_rd_reg && reply_cnt_reg == CNT_MSB)
                begin
                    reply_msb_next = itm_rx_reg;
                    reply_cnt_next = CNT_LSB;
                end
                else if (pend_rd_reg && reply_cnt_reg == CNT_LSB)
                begin
                    reply_lsb_next = itm_rx_reg;
                    reply_cnt_next = CNT_CHK;
                end
                else
                begin
                    awaiting_next  = 1'b0;
                    reply_cnt_next = CNT_MSB;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            itm_vld_reg   <= 1'b0;
            beat_idx_reg  <= '0;
            awaiting_reg  <= 1'b0;
            pend_rd_reg   <= 1'b0;
            reply_cnt_reg <= '0;
            reply_msb_reg <= '0;
            reply_lsb_reg <= '0;
            sent_chk_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                itm_vld_reg <= 1'b1;
            end
            else if (done)
            begin
                itm_vld_reg <= 1'b0;
            end
            beat_idx_reg  <= beat_idx_next;
            awaiting_reg  <= awaiting_next;
            pend_rd_reg   <= pend_rd_next;
            reply_cnt_reg <= reply_cnt_next;
            reply_msb_reg <= reply_msb_next;
            reply_lsb_reg <= reply_lsb_next;
            sent_chk_reg  <= sent_chk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            itm_op_reg   <= op;
            itm_rd_reg   <= is_read;
            itm_addr_reg <= reg_address;
            itm_val_reg  <= write_value;
            itm_rx_reg   <= rx_byte;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/mucf_out_stage.sv
`default_nettype none

module mucf_out_stage
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           beat_push,
    output logic                beat_ready,
    input  wire mucf_pkg::beat_t beat,
    output logic                out_valid,
    input  wire logic           out_ready,
    output mucf_pkg::beat_t     out_beat
);
    import mucf_pkg::*;

    logic  out_vld_reg;
    beat_t out_beat_reg;

    assign beat_ready = !out_vld_reg || out_ready;
    assign out_valid  = out_vld_reg;
    assign out_beat   = out_beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (beat_ready)
        begin
            out_vld_reg <= beat_push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat_push)
        begin
            out_beat_reg <= beat;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/meter_uart_command_framer_unit.sv
// channel | direction | beat
// in      | sink      | op, is_read, reg_address, write_value, rx_byte
// out     | source    | kind, tx_byte, frame_last, read_data, status
//
// a read command gives 3 frame beats, a write command 5, one beat per cycle while out_ready keeps the output moving
// a reply byte gives at most one result beat
// once the command is taken, its first beat passes through the input register and then the output register
// rst_n clears the item and output valids and all reply tracking state
// out_ready low holds the output register; the input side stalls once its beat is waiting
`default_nettype none

module meter_uart_command_framer_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        op,
    input  wire logic        is_read,
    input  wire logic [6:0]  reg_address,
    input  wire logic [15:0] write_value,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             kind,
    output logic [7:0]       tx_byte,
    output logic             frame_last,
    output logic [15:0]      read_data,
    output logic             status
);
    import mucf_pkg::*;

    logic  beat_push;
    logic  beat_ready;
    beat_t beat;
    beat_t out_beat;

    mucf_engine u_engine
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .is_read     (is_read),
        .reg_address (reg_address),
        .write_value (write_value),
        .rx_byte     (rx_byte),
        .beat_push   (beat_push),
        .beat_ready  (beat_ready),
        .beat        (beat)
    );

    mucf_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_push  (beat_push),
        .beat_ready (beat_ready),
        .beat       (beat),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_beat   (out_beat)
    );

    assign kind       = out_beat.kind;
    assign tx_byte    = out_beat.tx_byte;
    assign frame_last = out_beat.frame_last;
    assign read_data  = out_beat.read_data;
    assign status     = out_beat.status;

endmodule

`default_nettype wire

// File: hw/rtl/mucf_checker.sv
`default_nettype none

`include "meter_uart_command_framer_unit_assert.svh"

module mucf_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        op,
    input wire logic        is_read,
    input wire logic [6:0]  reg_address,
    input wire logic [15:0] write_value,
    input wire logic [7:0]  rx_byte,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        kind,
    input wire logic [7:0]  tx_byte,
    input wire logic        frame_last,
    input wire logic [15:0] read_data,
    input wire logic        status
);
    import mucf_pkg::*;

    `MUCF_ASSERT_NEXT(a_in_hold, in_valid && !in_ready,
        in_valid && $stable(op) && $stable(is_read) && $stable(reg_address)
        && $stable(write_value) && $stable(rx_byte),
        "in beat changed while waiting")
    `MUCF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(tx_byte) && $stable(read_data) && $stable(kind),
        "out beat changed while stalled")
    `MUCF_ASSERT_ALWAYS(a_tx_clean,
        !out_valid || kind != KIND_TX || (read_data == 16'd0 && status == 1'b0),
        "tx beat carries result fields")
    `MUCF_ASSERT_ALWAYS(a_res_clean,
        !out_valid || kind != KIND_RESULT || (tx_byte == 8'd0 && !frame_last),
        "result beat carries frame fields")
    `MUCF_ASSERT_ALWAYS(a_err_data,
        !out_valid || kind != KIND_RESULT || !status || read_data == ERR_DATA,
        "mismatch without error data")

endmodule

bind meter_uart_command_framer_unit mucf_checker u_mucf_checker (.*);

`default_nettype wire

// File: verif/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mucf_pkg::*;

    localparam int RANDOM_ITEMS   = 250;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int HOLD_OFF       = 200;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic        op          = OP_CMD;
    logic        is_read     = 1'b0;
    logic [6:0]  reg_address = '0;
    logic [15:0] write_value = '0;
    logic [7:0]  rx_byte     = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic        kind;
    logic [7:0]  tx_byte;
    logic        frame_last;
    logic [15:0] read_data;
    logic        status;

    // predictor state
    logic        reply_pending   = 1'b0;
    logic        reply_is_read   = 1'b0;
    logic [1:0]  reply_bytes_in  = '0;
    logic [7:0]  held_msb        = '0;
    logic [7:0]  held_lsb        = '0;
    logic [7:0]  frame_checksum  = '0;

    beat_t expected_beats[$];

    int  error_count    = 0;
    int  items_sent     = 0;
    int  commands_sent  = 0;
    int  replies_sent   = 0;
    int  beats_checked  = 0;
    int  results_checked = 0;
    int  idle_cycles    = 0;
    int  hold_request   = 0;
    bit  gaps_on        = 1'b1;

    meter_uart_command_framer_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .is_read     (is_read),
        .reg_address (reg_address),
        .write_value (write_value),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .tx_byte     (tx_byte),
        .frame_last  (frame_last),
        .read_data   (read_data),
        .status      (status)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void push_beat(logic k, logic [7:0] tx, logic last,
                                      logic [15:0] data, logic st);
        beat_t b;
        b.kind       = k;
        b.tx_byte    = tx;
        b.frame_last = last;
        b.read_data  = data;
        b.status     = st;
        expected_beats.push_back(b);
    endfunction

    // frame and reply tracking, one accepted beat at a time
    function automatic void predict_framer(logic item_op, logic item_rd,
                                           logic [6:0] item_addr,
                                           logic [15:0] item_value,
                                           logic [7:0] item_rx);
        logic [7:0] addr_byte;
        logic [7:0] chk;
        logic [7:0] sum;
        if (item_op == OP_CMD) begin
            addr_byte = {1'b0, item_addr};
            addr_byte[RW_BIT] = item_rd;
            if (item_rd)
                chk = addr_byte;
            else
                chk = addr_byte + item_value[15:8] + item_value[7:0];
            push_beat(KIND_TX, SYNC_BYTE, 1'b0, '0, 1'b0);
            push_beat(KIND_TX, addr_byte, 1'b0, '0, 1'b0);
            if (!item_rd) begin
                push_beat(KIND_TX, item_value[15:8], 1'b0, '0, 1'b0);
                push_beat(KIND_TX, item_value[7:0], 1'b0, '0, 1'b0);
            end
            push_beat(KIND_TX, chk, 1'b1, '0, 1'b0);
            reply_pending  = 1'b1;
            reply_is_read  = item_rd;
            reply_bytes_in = CNT_MSB;
            held_msb       = '0;
            held_lsb       = '0;
            frame_checksum = chk;
        end else if (reply_pending) begin
            if (reply_is_read && reply_bytes_in == CNT_MSB) begin
                held_msb       = item_rx;
                reply_bytes_in = CNT_LSB;
            end else if (reply_is_read && reply_bytes_in == CNT_LSB) begin
                held_lsb       = item_rx;
                reply_bytes_in = CNT_CHK;
            end else begin
                if (reply_is_read) begin
                    sum = held_msb + held_lsb;
                    if (item_rx == sum)
                        push_beat(KIND_RESULT, '0, 1'b0, {held_msb, held_lsb}, 1'b0);
                    else
                        push_beat(KIND_RESULT, '0, 1'b0, ERR_DATA, 1'b1);
                end else begin
                    push_beat(KIND_RESULT, '0, 1'b0, ERR_DATA, item_rx != frame_checksum);
                end
                reply_pending  = 1'b0;
                reply_bytes_in = CNT_MSB;
            end
        end
    endfunction

    task automatic send_item(input logic item_op, input logic item_rd,
                             input logic [6:0] item_addr, input logic [15:0] item_value,
                             input logic [7:0] item_rx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= item_op;
        is_read     <= item_rd;
        reg_address <= item_addr;
        write_value <= item_value;
        rx_byte     <= item_rx;
        do
            @(negedge clk);
        while (!in_ready);
        if (item_op == OP_CMD || reply_pending)
            items_sent++;
        if (item_op == OP_CMD)
            commands_sent++;
        else
            replies_sent++;
        predict_framer(item_op, item_rd, item_addr, item_value, item_rx);
        @(posedge clk);
    endtask

    task automatic send_command(input logic rd, input logic [6:0] addr,
                                input logic [15:0] value);
        send_item(OP_CMD, rd, addr, value, 8'($urandom));
    endtask

    task automatic send_reply(input logic [7:0] b);
        send_item(OP_REPLY, 1'($urandom), 7'($urandom), 16'($urandom), b);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_beats.size() != 0);
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("tb: mismatch on %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // output beat checking
    always @(negedge clk) begin
        beat_t want;
        if (rst_n && out_valid && out_ready) begin
            beats_checked++;
            if (expected_beats.size() == 0) begin
                report_mismatch("beat with nothing expected", 32'(tx_byte), 0);
            end else begin
                want = expected_beats.pop_front();
                if (want.kind == KIND_RESULT)
                    results_checked++;
                if (kind !== want.kind)
                    report_mismatch("kind", 32'(kind), 32'(want.kind));
                if (tx_byte !== want.tx_byte)
                    report_mismatch("tx_byte", 32'(tx_byte), 32'(want.tx_byte));
                if (frame_last !== want.frame_last)
                    report_mismatch("frame_last", 32'(frame_last), 32'(want.frame_last));
                if (read_data !== want.read_data)
                    report_mismatch("read_data", 32'(read_data), 32'(want.read_data));
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
            end
        end
    end

    always @(negedge clk) begin
        if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: stalled for %0d cycles, %0d beats outstanding",
                     idle_cycles, expected_beats.size());
            $display("tb: errors");
            $finish;
        end
    end

    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                stall_left = pick_gap();
                out_ready <= (stall_left == 0);
            end
        end
    end

    task automatic test_frame_extremes();
        send_command(1'b1, 7'd0, 16'h0000);
        send_reply(8'h00);
        send_reply(8'h00);
        send_reply(8'h00);
        send_command(1'b1, 7'd127, 16'hFFFF);
        send_reply(8'hFF);
        send_reply(8'hFF);
        send_reply(8'hFE);
        send_command(1'b0, 7'd0, 16'h0000);
        send_reply(frame_checksum);
        send_command(1'b0, 7'd127, 16'hFFFF);
        send_reply(frame_checksum);
        send_command(1'b0, 7'h2A, 16'h8001);
        send_reply(frame_checksum);
    endtask

    task automatic test_reply_corner_cases();
        // bad read checksum
        send_command(1'b1, 7'h55, 16'hA5A5);
        send_reply(8'h12);
        send_reply(8'h34);
        send_reply(8'h00);
        // write echo mismatch
        send_command(1'b0, 7'h33, 16'h5AA5);
        send_reply(frame_checksum ^ 8'h01);
        // stray reply with nothing pending
        send_reply(8'h5A);
        // read abandoned after one reply byte
        send_command(1'b1, 7'h10, 16'h0000);
        send_reply(8'h77);
        send_command(1'b0, 7'h11, 16'h1234);
        send_reply(frame_checksum);
        // write abandoned before its echo, checksum wraps on the read
        send_command(1'b0, 7'h7F, 16'h00FF);
        send_command(1'b1, 7'h01, 16'hFFFF);
        send_reply(8'h80);
        send_reply(8'h80);
        send_reply(8'h00);
    endtask

    task automatic test_output_backpressure();
        gaps_on = 1'b0;
        hold_request = HOLD_OFF;
        repeat (8)
            send_command(1'b0, 7'($urandom), 16'($urandom));
        send_reply(frame_checksum);
        wait_drained();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int          shape;
        int          n;
        logic        rd;
        logic [7:0]  msb;
        logic [7:0]  lsb;
        logic [7:0]  chk;
        while (items_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 15) == 0)
                gaps_on = !gaps_on;
            shape = $urandom_range(0, 99);
            rd    = 1'($urandom);
            send_command(rd, 7'($urandom), 16'($urandom));
            if (shape < 82) begin
                if (rd) begin
                    msb = 8'($urandom);
                    lsb = 8'($urandom);
                    chk = msb + lsb;
                    if ($urandom_range(0, 3) == 0)
                        chk = 8'($urandom);
                    send_reply(msb);
                    send_reply(lsb);
                    send_reply(chk);
                end else begin
                    chk = frame_checksum;
                    if ($urandom_range(0, 3) == 0)
                        chk = 8'($urandom);
                    send_reply(chk);
                end
                if (shape >= 74) begin
                    n = $urandom_range(1, 2);
                    repeat (n)
                        send_reply(8'($urandom));
                end
            end else if (rd) begin
                // partial read reply, the next command abandons it
                n = $urandom_range(0, 2);
                repeat (n)
                    send_reply(8'($urandom));
            end
            if ($urandom_range(0, 40) == 0)
                wait_drained();
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_reply(8'hC3);
        test_frame_extremes();
        test_reply_corner_cases();
        test_output_backpressure();
        test_random_traffic();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("tb: %0d commands and %0d reply bytes sent, %0d beats checked",
                 commands_sent, replies_sent, beats_checked);
        $display("tb: %0d transaction results, %0d mismatches, long output hold-off included",
                 results_checked, error_count);
        if (error_count == 0 && expected_beats.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

`default_nettype wire

// File: meter_uart_command_framer_unit.f
+incdir+hw/rtl
hw/rtl/mucf_pkg.sv
hw/rtl/mucf_engine.sv
hw/rtl/mucf_out_stage.sv
hw/rtl/meter_uart_command_framer_unit.sv
hw/rtl/mucf_checker.sv
verif/tb.sv
